// File: rtl/ghash_pkg.sv
// ----------------------------------------------------------------------------
// ghash_pkg
// shared types and constants for the gf(2^128) ghash accumulator
// ----------------------------------------------------------------------------
package ghash_pkg;

  localparam int GF_BITS        = 128;
  localparam int HALF_BITS      = 64;
  localparam int DIGIT_BITS_DEF = 8;

  // reduction constant 0xe1 placed in the top byte
  localparam logic [GF_BITS-1:0] REDUCE_POLY = {8'he1, {(GF_BITS-8){1'b0}}};

  // register indexes of the configuration port
  localparam int                CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 1'b1;

  typedef logic [GF_BITS-1:0] gf_elem_t;

  typedef struct packed {
    logic start;
    logic ack;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// File: rtl/ghash_mul.sv
// ----------------------------------------------------------------------------
// ghash_mul
// digit-serial gf(2^128) multiplier, one multiplier digit per cycle
// ----------------------------------------------------------------------------
module ghash_mul
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mul_ctrl_t ctrl,
  input  gf_elem_t  x_in,
  input  gf_elem_t  h_in,
  output mul_stat_t stat,
  output gf_elem_t  z
);

  localparam int NUM_DIGITS = (GF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  gf_elem_t         x_r, x_nxt;
  gf_elem_t         y_r, y_nxt;
  gf_elem_t         z_r, z_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  gf_elem_t step_y;
  gf_elem_t step_z;

  // one digit of the right-shift multiply
  always_comb begin
    step_y = y_r;
    step_z = z_r;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      if (x_r[GF_BITS-1-i]) begin
        step_z = step_z ^ step_y;
      end
      if (step_y[0]) begin
        step_y = (step_y >> 1) ^ REDUCE_POLY;
      end else begin
        step_y = step_y >> 1;
      end
    end
  end

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (ctrl.ack) begin
      done_nxt = 1'b0;
    end
    if (ctrl.start) begin
      x_nxt    = x_in;
      y_nxt    = h_in;
      z_nxt    = '0;
      cnt_nxt  = CNT_W'(NUM_DIGITS - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      x_nxt = x_r << DIGIT_BITS;
      y_nxt = step_y;
      z_nxt = step_z;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign z         = z_r;

endmodule

// File: rtl/ghash_gf128_accumulator.sv
// ----------------------------------------------------------------------------
// ghash_gf128_accumulator
// ghash accumulator: folds 128-bit blocks into a running product with h
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       in_start_req, in_last,
//                                               in_block_hi, in_block_lo
// out      output     out_valid / out_stall     out_digest_hi, out_digest_lo
// cfg      input      cfg_wr_en                 cfg_index, cfg_data
//
// each transaction runs the block through the digit-serial multiplier, and the
// result becomes the accumulator that feeds the next block.
// reset clears the key, the accumulator and all handshake state.
// a held digest stalls completion of the next last block until it is taken.
// ----------------------------------------------------------------------------
module ghash_gf128_accumulator
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HALF_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_req,
  input  logic                 in_last,
  input  logic [HALF_BITS-1:0] in_block_hi,
  input  logic [HALF_BITS-1:0] in_block_lo,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [HALF_BITS-1:0] out_digest_hi,
  output logic [HALF_BITS-1:0] out_digest_lo
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MUL  = 1'b1;

  logic                 state_r, state_nxt;
  logic [HALF_BITS-1:0] key_hi_r, key_lo_r;
  gf_elem_t             acc_r, acc_nxt;
  logic                 last_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [HALF_BITS-1:0] dig_hi_r, dig_lo_r;

  mul_ctrl_t mul_ctrl;
  mul_stat_t mul_stat;
  gf_elem_t  mul_x;
  gf_elem_t  mul_z;
  logic      in_fire;
  logic      out_fire;
  logic      can_finish;
  logic      finish;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_fire   = out_valid_r && !out_stall;
  assign can_finish = !last_r || !out_valid_r || !out_stall;
  assign finish     = (state_r == ST_MUL) && mul_stat.done && can_finish;

  assign mul_x          = (in_start_req ? '0 : acc_r) ^ {in_block_hi, in_block_lo};
  assign mul_ctrl.start = in_fire;
  assign mul_ctrl.ack   = finish;

  ghash_mul #(
    .DIGIT_BITS(DIGIT_BITS)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (mul_ctrl),
    .x_in (mul_x),
    .h_in ({key_hi_r, key_lo_r}),
    .stat (mul_stat),
    .z    (mul_z)
  );

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (finish) begin
          state_nxt = ST_IDLE;
          acc_nxt   = mul_z;
          if (last_r) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KEY_HI: key_hi_r <= cfg_data;
          REG_KEY_LO: key_lo_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= in_last;
    end
    if (finish && last_r) begin
      dig_hi_r <= mul_z[GF_BITS-1:HALF_BITS];
      dig_lo_r <= mul_z[HALF_BITS-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_digest_hi = dig_hi_r;
  assign out_digest_lo = dig_lo_r;

  // accepted transaction keeps the input side stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled after accept");

  // multiplier never reports running and finished at once
  a_mul_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && mul_stat.done))
    else $error("multiplier busy and done together");

  // a digest appears only at the end of a multiply
  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(finish && last_r))
    else $error("digest without finished last block");

  // idle block has no multiply in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mul_stat.busy && !mul_stat.done)
    else $error("multiplier active while idle");

endmodule

// File: bench/ghash_gf128_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_gf128_accumulator_tb
// self-checking bench for the gf(2^128) ghash accumulator: a directed run over
// key and block extremes, chained and restarted messages and a key change in
// the middle of a message, then random messages under three idling patterns,
// each digest checked against a bit-serial gcm multiply kept in the bench
// ----------------------------------------------------------------------------
module ghash_gf128_accumulator_tb;
  import ghash_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEG_ITEMS     = 88;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [HALF_BITS-1:0] hi;
    logic [HALF_BITS-1:0] lo;
  } digest_t;

  class ghash_scoreboard;
    gf_elem_t hash_key;
    gf_elem_t running_sum;
    digest_t  pending_digests[$];
    int       blocks_noted;
    int       digests_checked;

    function new();
      hash_key        = '0;
      running_sum     = '0;
      blocks_noted    = 0;
      digests_checked = 0;
    endfunction

    function void write_key(logic [CFG_IDX_W-1:0] idx, logic [HALF_BITS-1:0] data);
      case (idx)
        REG_KEY_HI: hash_key[GF_BITS-1:HALF_BITS] = data;
        REG_KEY_LO: hash_key[HALF_BITS-1:0] = data;
        default: ;
      endcase
    endfunction

    // gcm bit order: vector bit 127 is bit 0 of the field element
    function gf_elem_t gf_mul_key(gf_elem_t x, gf_elem_t y);
      gf_elem_t z;
      z = '0;
      for (int i = GF_BITS - 1; i >= 0; i--) begin
        if (x[i]) z ^= y;
        y = y[0] ? ((y >> 1) ^ REDUCE_POLY) : (y >> 1);
      end
      return z;
    endfunction

    function void note_block(bit start, bit last, logic [HALF_BITS-1:0] hi,
                             logic [HALF_BITS-1:0] lo);
      if (start) running_sum = '0;
      running_sum = gf_mul_key(running_sum ^ {hi, lo}, hash_key);
      blocks_noted++;
      if (last) pending_digests.push_back(running_sum);
    endfunction

    function void check_digest(logic [HALF_BITS-1:0] hi, logic [HALF_BITS-1:0] lo,
                               output bit unexpected, output bit bad_hi,
                               output bit bad_lo, output digest_t want);
      unexpected = 1'b0;
      bad_hi     = 1'b0;
      bad_lo     = 1'b0;
      want       = '0;
      if (pending_digests.size() == 0) begin
        unexpected = 1'b1;
        return;
      end
      want = pending_digests.pop_front();
      digests_checked++;
      bad_hi = (hi !== want.hi);
      bad_lo = (lo !== want.lo);
    endfunction

    function int pending();
      return pending_digests.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_HI;
  logic [HALF_BITS-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_start_req = 1'b0;
  logic                 in_last = 1'b0;
  logic [HALF_BITS-1:0] in_block_hi = '0;
  logic [HALF_BITS-1:0] in_block_lo = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [HALF_BITS-1:0] out_digest_hi;
  logic [HALF_BITS-1:0] out_digest_lo;

  ghash_scoreboard sb = new();
  int  mismatches = 0;
  int  cycle_count = 0;
  int  src_idle = 34;
  int  sink_idle = 53;
  int  hold_request = 0;
  int  key_settings = 0;

  ghash_gf128_accumulator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_req  (in_start_req),
    .in_last       (in_last),
    .in_block_hi   (in_block_hi),
    .in_block_lo   (in_block_lo),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digest_hi (out_digest_hi),
    .out_digest_lo (out_digest_lo)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digests outstanding", cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic take_digest(input logic [HALF_BITS-1:0] hi, input logic [HALF_BITS-1:0] lo);
    digest_t want;
    bit      unexpected;
    bit      bad_hi;
    bit      bad_lo;
    sb.check_digest(hi, lo, unexpected, bad_hi, bad_lo, want);
    if (unexpected) report_mismatch($sformatf("unexpected digest %h_%h", hi, lo));
    if (bad_hi) report_mismatch($sformatf("digest_hi %h, expected %h", hi, want.hi));
    if (bad_lo) report_mismatch($sformatf("digest_lo %h, expected %h", lo, want.lo));
  endtask

  // result side: checks each transaction, random stall or a long hold-off
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) take_digest(out_digest_hi, out_digest_lo);
      if (hold_request != 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle);
      end
    end
  end

  function automatic logic [HALF_BITS-1:0] pick_half();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(input bit start, input bit last, input logic [HALF_BITS-1:0] hi,
                            input logic [HALF_BITS-1:0] lo);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_last      <= last;
    in_block_hi  <= hi;
    in_block_lo  <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_block(start, last, hi, lo);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_hash_key(input logic [HALF_BITS-1:0] hi, input logic [HALF_BITS-1:0] lo);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_KEY_HI;
    cfg_data  <= hi;
    @(posedge clk);
    sb.write_key(REG_KEY_HI, hi);
    cfg_index <= REG_KEY_LO;
    cfg_data  <= lo;
    @(posedge clk);
    sb.write_key(REG_KEY_LO, lo);
    cfg_wr_en <= 1'b0;
    key_settings++;
  endtask

  // mostly well-formed messages, some with scrambled start and last flags
  task automatic send_messages(input int n_items);
    int sent;
    int len;
    bit start;
    bit last;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(9) == 0) begin
          start = $urandom_range(1);
          last  = $urandom_range(1);
        end else begin
          start = (k == 0) && ($urandom_range(7) != 0);
          last  = (k == len - 1);
        end
        send_block(start, last, pick_half(), pick_half());
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [HALF_BITS-1:0] top_bit;
    top_bit = 64'h8000_0000_0000_0000;
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // zero key after reset, no start on the first block
    send_block(1'b0, 1'b1, '1, '1);
    wait_idle();

    // identity key: digests equal the running xor of the blocks
    set_hash_key(top_bit, '0);
    send_block(1'b0, 1'b1, pick_half(), pick_half());
    send_block(1'b0, 1'b1, top_bit, 64'd1);
    send_block(1'b1, 1'b1, '1, '1);
    send_block(1'b1, 1'b0, '0, '0);
    send_block(1'b0, 1'b0, '1, '0);
    send_block(1'b0, 1'b1, '0, '1);
    wait_idle();

    set_hash_key('1, '1);
    send_block(1'b1, 1'b1, '1, '1);
    send_block(1'b1, 1'b1, '0, '0);
    send_block(1'b1, 1'b0, pick_half(), pick_half());
    send_block(1'b0, 1'b0, pick_half(), pick_half());
    wait_idle();

    // new key in the middle of a message
    set_hash_key('0, 64'd1);
    send_block(1'b0, 1'b1, pick_half(), pick_half());
    send_block(1'b1, 1'b1, top_bit, '0);
    send_block(1'b1, 1'b1, '0, 64'd1);
    wait_idle();

    // long receiver hold-off so the block backs up onto its input
    set_hash_key({$urandom, $urandom}, {$urandom, $urandom});
    hold_request = 1;
    for (int i = 0; i < 10; i++) send_block(1'b1, 1'b1, pick_half(), pick_half());
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle = 34; sink_idle = 53; end
        1: begin src_idle = 53; sink_idle = 34; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        if (seg == 0) set_hash_key({$urandom, $urandom}, {$urandom, $urandom});
        else set_hash_key(pick_half(), pick_half());
        send_messages(SEG_ITEMS);
        wait_idle();
      end
    end

    if (sb.pending() != 0) report_mismatch($sformatf("%0d digests never arrived", sb.pending()));
    $display("covered %0d blocks and %0d digests across %0d key settings", sb.blocks_noted,
             sb.digests_checked, key_settings);
    $display("idling: sender-heavy, receiver-heavy and none, plus one long receiver hold-off");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
